// ===== rtl/cubtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic trajectory point package
// Widths, lane codes and the divider lane record shared by the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cubtr_pkg;

   localparam int DATA_W    = 32;
   localparam int DEN_W     = 3 * DATA_W;
   localparam int DIV_STEPS = 34;
   localparam int NUM_W     = DEN_W + DIV_STEPS;
   localparam int Q_W       = DIV_STEPS;
   localparam int SUM_W     = Q_W + 3;
   localparam int K_W       = DATA_W + 2;
   localparam int NLANE     = 3;

   localparam int LANE_POS = 0;
   localparam int LANE_VEL = 1;
   localparam int LANE_ACC = 2;

   localparam logic [DATA_W-1:0] DURATION_RESET = 32'd65536;
   localparam logic [DATA_W-1:0] POS_LIMIT      = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] NEG_LIMIT      = 32'h8000_0000;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [Q_W-1:0]   quo;
      logic             neg;
      logic             huge;
   } lane_type;

endpackage

`default_nettype wire

// ===== rtl/cubic_trajectory_point.sv =====
// ----------------------------------------------------------------------------
// Cubic trajectory point
// Rest-to-rest cubic position, velocity and acceleration at one sample time.
// ----------------------------------------------------------------------------
// A request carries start point, end point and sample time (Q16.16). The
// response carries position, velocity and acceleration, each floored once and
// clipped to signed 32 bits, plus a flag set when any of them was clipped.
// The move duration comes from the csr channel, which is always ready; write
// it only while no request is in flight.
// Six arithmetic stages form the numerators and the cube of the duration
// with multipliers of at most 32 by 34 bits. An entry stage checks the quotients for
// overflow, then three parallel restoring dividers retire one quotient bit
// per stage over 34 stages, and a final stage does the rounding and
// clipping into the response register.
// One request is accepted every cycle, limited by nothing but the response channel.
// When the receiver stalls, the whole pipeline holds and req_ready drops
// only while a finished response is waiting. Reset empties the pipeline and
// restores the duration to one second.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_trajectory_point (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [31:0]  req_start_point,
   input  wire logic signed [31:0]  req_end_point,
   input  wire logic        [31:0]  req_sample_time,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_position,
   output logic signed [31:0]       rsp_velocity,
   output logic signed [31:0]       rsp_acceleration,
   output logic                     rsp_saturated,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic        [31:0]  csr_move_duration
);

   localparam int DW    = cubtr_pkg::DATA_W;
   localparam int KW    = cubtr_pkg::K_W;
   localparam int NW    = cubtr_pkg::NUM_W;
   localparam int DENW  = cubtr_pkg::DEN_W;
   localparam int STEPS = cubtr_pkg::DIV_STEPS;
   localparam int QW    = cubtr_pkg::Q_W;
   localparam int SW    = cubtr_pkg::SUM_W;
   localparam int NL    = cubtr_pkg::NLANE;
   localparam int VLD_N = 6 + STEPS + 1;

   logic              adv;
   logic [VLD_N-1:0]  vld_ff;
   logic [DW-1:0]     duration_ff;

   // stage 1
   logic signed [DW-1:0] s1_start_ff;
   logic [DW-1:0]  s1_dm_ff, s1_tq_ff, s1_t_ff, s1_kv_ff;
   logic [KW-1:0]  s1_kp_ff, s1_ka_ff;
   logic           s1_dneg_ff, s1_kp_neg_ff, s1_kv_neg_ff, s1_ka_neg_ff;
   logic [DW-1:0]  t_eff;
   logic [DW:0]    d_diff, kv_full;
   logic [KW:0]    kp_full, ka_full;
   // stage 2
   logic signed [DW-1:0] s2_start_ff;
   logic [DW-1:0]  s2_tq_ff, s2_t_ff, s2_kv_ff;
   logic [KW-1:0]  s2_kp_ff;
   logic           s2_pneg_ff, s2_vneg_ff, s2_aneg_ff;
   logic [2*DW-1:0] s2_t2_ff, s2_atq_ff;
   logic [DW+KW-1:0] s2_aka_ff;
   // stage 3
   logic signed [DW-1:0] s3_start_ff;
   logic [KW-1:0]  s3_kp_ff;
   logic           s3_pneg_ff, s3_vneg_ff, s3_aneg_ff;
   logic [2*DW-1:0] s3_dp0_ff, s3_dp1_ff, s3_ap0_ff, s3_ap1_ff, s3_vp0_ff, s3_vp1_ff;
   logic [DW+KW+2:0] s3_aka6_ff;
   // stage 4
   logic signed [DW-1:0] s4_start_ff;
   logic [KW-1:0]  s4_kp_ff;
   logic           s4_pneg_ff, s4_vneg_ff, s4_aneg_ff;
   logic [DENW-1:0] s4_den_ff, s4_atq2_ff, s4_atqkv_ff;
   logic [DW+KW+2:0] s4_aka6_ff;
   // stage 5
   logic signed [DW-1:0] s5_start_ff;
   logic           s5_pneg_ff, s5_vneg_ff, s5_aneg_ff;
   logic [DENW-1:0] s5_den_ff;
   logic [DW+KW-1:0] s5_pp0_ff, s5_pp1_ff, s5_pp2_ff;
   logic [DENW+2:0] s5_vel6_ff;
   logic [DW+KW+2:0] s5_aka6_ff;
   // stage 6
   logic signed [DW-1:0] s6_start_ff;
   logic           s6_pneg_ff, s6_vneg_ff, s6_aneg_ff;
   logic [DENW-1:0] s6_den_ff;
   logic [NW-1:0]   s6_pnum_ff, s6_vnum_ff, s6_anum_ff;
   logic [NW-1:0]   s6_lim;
   // divider stages
   cubtr_pkg::lane_type dv_lane_ff [0:STEPS][NL];
   cubtr_pkg::lane_type dv_lane_in [0:STEPS][NL];
   logic [DENW-1:0]      dv_den_ff   [0:STEPS];
   logic signed [DW-1:0] dv_start_ff [0:STEPS];
   logic [NW-1:0]        dv_shift    [0:STEPS-1];
   logic [NW:0]          dv_diff     [0:STEPS-1][NL];
   logic [NW-1:0]        s6_num      [NL];
   // final rounding and clipping
   logic [QW:0]     fin_mag  [NL];
   logic [SW-1:0]   fin_base [NL];
   logic [SW-1:0]   fin_sum  [NL];
   logic [DW-1:0]   fin_val  [NL];
   logic            fin_sat  [NL];
   logic            rsp_valid_ff;
   logic [DW-1:0]   rsp_pos_ff, rsp_vel_ff, rsp_acc_ff;
   logic            rsp_sat_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff  <= cubtr_pkg::DURATION_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            duration_ff <= csr_move_duration;
         end
         if (adv) begin
            vld_ff       <= {vld_ff[VLD_N-2:0], req_valid};
            rsp_valid_ff <= vld_ff[VLD_N-1];
         end
      end
   end

   // Stage 1: distance and the three time factors as sign and magnitude.
   always_comb begin
      t_eff   = (duration_ff == '0) ? DW'(1) : duration_ff;
      d_diff  = {req_end_point[DW-1], req_end_point} -
                {req_start_point[DW-1], req_start_point};
      kp_full = {3'b0, t_eff} + {2'b0, t_eff, 1'b0} - {2'b0, req_sample_time, 1'b0};
      kv_full = {1'b0, t_eff} - {1'b0, req_sample_time};
      ka_full = {3'b0, t_eff} - {2'b0, req_sample_time, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_start_ff  <= req_start_point;
         s1_dneg_ff   <= d_diff[DW];
         s1_dm_ff     <= d_diff[DW] ? DW'(-d_diff) : d_diff[DW-1:0];
         s1_tq_ff     <= req_sample_time;
         s1_t_ff      <= t_eff;
         s1_kp_neg_ff <= kp_full[KW];
         s1_kp_ff     <= kp_full[KW] ? KW'(-kp_full) : kp_full[KW-1:0];
         s1_kv_neg_ff <= kv_full[DW];
         s1_kv_ff     <= kv_full[DW] ? DW'(-kv_full) : kv_full[DW-1:0];
         s1_ka_neg_ff <= ka_full[KW];
         s1_ka_ff     <= ka_full[KW] ? KW'(-ka_full) : ka_full[KW-1:0];

         // Stage 2: first products.
         s2_start_ff <= s1_start_ff;
         s2_tq_ff    <= s1_tq_ff;
         s2_t_ff     <= s1_t_ff;
         s2_kv_ff    <= s1_kv_ff;
         s2_kp_ff    <= s1_kp_ff;
         s2_pneg_ff  <= s1_dneg_ff ^ s1_kp_neg_ff;
         s2_vneg_ff  <= s1_dneg_ff ^ s1_kv_neg_ff;
         s2_aneg_ff  <= s1_dneg_ff ^ s1_ka_neg_ff;
         s2_t2_ff    <= s1_t_ff * s1_t_ff;
         s2_atq_ff   <= s1_dm_ff * s1_tq_ff;
         s2_aka_ff   <= s1_dm_ff * s1_ka_ff;

         // Stage 3: partial products by 32-bit halves.
         s3_start_ff <= s2_start_ff;
         s3_kp_ff    <= s2_kp_ff;
         s3_pneg_ff  <= s2_pneg_ff;
         s3_vneg_ff  <= s2_vneg_ff;
         s3_aneg_ff  <= s2_aneg_ff;
         s3_dp0_ff   <= s2_t2_ff[DW-1:0] * s2_t_ff;
         s3_dp1_ff   <= s2_t2_ff[2*DW-1:DW] * s2_t_ff;
         s3_ap0_ff   <= s2_atq_ff[DW-1:0] * s2_tq_ff;
         s3_ap1_ff   <= s2_atq_ff[2*DW-1:DW] * s2_tq_ff;
         s3_vp0_ff   <= s2_atq_ff[DW-1:0] * s2_kv_ff;
         s3_vp1_ff   <= s2_atq_ff[2*DW-1:DW] * s2_kv_ff;
         s3_aka6_ff  <= {s2_aka_ff, 2'b0} + {1'b0, s2_aka_ff, 1'b0};

         // Stage 4: gather the halves.
         s4_start_ff <= s3_start_ff;
         s4_kp_ff    <= s3_kp_ff;
         s4_pneg_ff  <= s3_pneg_ff;
         s4_vneg_ff  <= s3_vneg_ff;
         s4_aneg_ff  <= s3_aneg_ff;
         s4_aka6_ff  <= s3_aka6_ff;
         s4_den_ff   <= DENW'(s3_dp0_ff) + {s3_dp1_ff, {DW{1'b0}}};
         s4_atq2_ff  <= DENW'(s3_ap0_ff) + {s3_ap1_ff, {DW{1'b0}}};
         s4_atqkv_ff <= DENW'(s3_vp0_ff) + {s3_vp1_ff, {DW{1'b0}}};

         // Stage 5: position factor by thirds, velocity scaled by six.
         s5_start_ff <= s4_start_ff;
         s5_pneg_ff  <= s4_pneg_ff;
         s5_vneg_ff  <= s4_vneg_ff;
         s5_aneg_ff  <= s4_aneg_ff;
         s5_aka6_ff  <= s4_aka6_ff;
         s5_den_ff   <= s4_den_ff;
         s5_pp0_ff   <= s4_atq2_ff[DW-1:0] * s4_kp_ff;
         s5_pp1_ff   <= s4_atq2_ff[2*DW-1:DW] * s4_kp_ff;
         s5_pp2_ff   <= s4_atq2_ff[3*DW-1:2*DW] * s4_kp_ff;
         s5_vel6_ff  <= {s4_atqkv_ff, 2'b0} + {1'b0, s4_atqkv_ff, 1'b0};

         // Stage 6: numerators aligned to the output scale.
         s6_start_ff <= s5_start_ff;
         s6_pneg_ff  <= s5_pneg_ff;
         s6_vneg_ff  <= s5_vneg_ff;
         s6_aneg_ff  <= s5_aneg_ff;
         s6_den_ff   <= s5_den_ff;
         s6_pnum_ff  <= NW'(s5_pp0_ff) + (NW'(s5_pp1_ff) << DW) + (NW'(s5_pp2_ff) << (2 * DW));
         s6_vnum_ff  <= NW'(s5_vel6_ff) << (DW / 2);
         s6_anum_ff  <= NW'(s5_aka6_ff) << DW;
      end
   end

   // Divider: entry decides whether the quotient overflows the kept bits,
   // then each stage compares against the denominator at one bit position.
   always_comb begin
      s6_lim = NW'(s6_den_ff) << STEPS;
      s6_num[cubtr_pkg::LANE_POS] = s6_pnum_ff;
      s6_num[cubtr_pkg::LANE_VEL] = s6_vnum_ff;
      s6_num[cubtr_pkg::LANE_ACC] = s6_anum_ff;
      for (int l = 0; l < NL; l++) begin
         dv_lane_in[0][l].rem  = s6_num[l];
         dv_lane_in[0][l].quo  = '0;
         dv_lane_in[0][l].huge = (s6_num[l] >= s6_lim);
      end
      dv_lane_in[0][cubtr_pkg::LANE_POS].neg = s6_pneg_ff;
      dv_lane_in[0][cubtr_pkg::LANE_VEL].neg = s6_vneg_ff;
      dv_lane_in[0][cubtr_pkg::LANE_ACC].neg = s6_aneg_ff;
      for (int i = 0; i < STEPS; i++) begin
         dv_shift[i] = NW'(dv_den_ff[i]) << (STEPS - 1 - i);
         for (int l = 0; l < NL; l++) begin
            dv_diff[i][l] = {1'b0, dv_lane_ff[i][l].rem} - {1'b0, dv_shift[i]};
            dv_lane_in[i+1][l].neg  = dv_lane_ff[i][l].neg;
            dv_lane_in[i+1][l].huge = dv_lane_ff[i][l].huge;
            dv_lane_in[i+1][l].quo  = {dv_lane_ff[i][l].quo[QW-2:0], !dv_diff[i][l][NW]};
            dv_lane_in[i+1][l].rem  = dv_diff[i][l][NW] ? dv_lane_ff[i][l].rem
                                                        : dv_diff[i][l][NW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_den_ff[0]   <= s6_den_ff;
         dv_start_ff[0] <= s6_start_ff;
         for (int i = 0; i <= STEPS; i++) begin
            for (int l = 0; l < NL; l++) begin
               dv_lane_ff[i][l] <= dv_lane_in[i][l];
            end
         end
         for (int i = 1; i <= STEPS; i++) begin
            dv_den_ff[i]   <= dv_den_ff[i-1];
            dv_start_ff[i] <= dv_start_ff[i-1];
         end
      end
   end

   // Floor of a negative value takes one more unit when the remainder is
   // nonzero; the result clips on overflow or if bits 31 and up disagree.
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         fin_mag[l]  = {1'b0, dv_lane_ff[STEPS][l].quo} +
                       (QW+1)'(dv_lane_ff[STEPS][l].neg && (dv_lane_ff[STEPS][l].rem != '0));
         fin_base[l] = '0;
         if (l == cubtr_pkg::LANE_POS) begin
            fin_base[l] = SW'(dv_start_ff[STEPS]);
         end
         fin_sum[l] = dv_lane_ff[STEPS][l].neg ? fin_base[l] - SW'(fin_mag[l])
                                               : fin_base[l] + SW'(fin_mag[l]);
         if (dv_lane_ff[STEPS][l].huge) begin
            fin_sat[l] = 1'b1;
            fin_val[l] = dv_lane_ff[STEPS][l].neg ? cubtr_pkg::NEG_LIMIT
                                                  : cubtr_pkg::POS_LIMIT;
         end else if (fin_sum[l][SW-1:DW-1] != '0 && fin_sum[l][SW-1:DW-1] != '1) begin
            fin_sat[l] = 1'b1;
            fin_val[l] = fin_sum[l][SW-1] ? cubtr_pkg::NEG_LIMIT : cubtr_pkg::POS_LIMIT;
         end else begin
            fin_sat[l] = 1'b0;
            fin_val[l] = fin_sum[l][DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pos_ff <= fin_val[cubtr_pkg::LANE_POS];
         rsp_vel_ff <= fin_val[cubtr_pkg::LANE_VEL];
         rsp_acc_ff <= fin_val[cubtr_pkg::LANE_ACC];
         rsp_sat_ff <= fin_sat[cubtr_pkg::LANE_POS] || fin_sat[cubtr_pkg::LANE_VEL] ||
                       fin_sat[cubtr_pkg::LANE_ACC];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_acceleration = rsp_acc_ff;
   assign rsp_saturated    = rsp_sat_ff;

`ifndef SYNTH
   // A request that enters the divider unclipped must leave room for the kept bits.
   a_div_entry_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[6] && !dv_lane_ff[0][cubtr_pkg::LANE_POS].huge) |->
      (dv_lane_ff[0][cubtr_pkg::LANE_POS].rem < (NW'(dv_den_ff[0]) << STEPS)))
      else $error("position numerator out of divider range");

   // After the last step the remainder is below the denominator.
   a_div_exit_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[VLD_N-1] && !dv_lane_ff[STEPS][cubtr_pkg::LANE_ACC].huge) |->
      (dv_lane_ff[STEPS][cubtr_pkg::LANE_ACC].rem < NW'(dv_den_ff[STEPS])))
      else $error("acceleration remainder not reduced");

   // An overflowing quotient must show up as a clipped response.
   a_huge_flags: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[VLD_N-1] && adv && (dv_lane_ff[STEPS][cubtr_pkg::LANE_POS].huge ||
       dv_lane_ff[STEPS][cubtr_pkg::LANE_VEL].huge ||
       dv_lane_ff[STEPS][cubtr_pkg::LANE_ACC].huge)) |=> (rsp_valid && rsp_saturated))
      else $error("overflow without saturation flag");

   // The duration comes out of reset at one second.
   a_duration_reset: assert property (@(posedge clock)
      $past(reset) |-> (duration_ff == cubtr_pkg::DURATION_RESET))
      else $error("duration not restored by reset");
`endif

endmodule

`default_nettype wire

// ===== test/cubic_trajectory_point_test.sv =====
// ----------------------------------------------------------------------------
// Cubic trajectory point testbench
// Drives requests and duration writes into the evaluator, predicts every
// response with exact wide arithmetic, and checks the responses in order
// under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_trajectory_point_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [cubtr_pkg::DATA_W-1:0] start_pt;
      logic signed [cubtr_pkg::DATA_W-1:0] end_pt;
      logic        [cubtr_pkg::DATA_W-1:0] when_t;
   } move_request_type;

   typedef struct {
      logic signed [cubtr_pkg::DATA_W-1:0] position;
      logic signed [cubtr_pkg::DATA_W-1:0] velocity;
      logic signed [cubtr_pkg::DATA_W-1:0] acceleration;
      logic                                saturated;
   } profile_point_type;

   typedef logic [255:0] wide_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_start_point = '0;
   logic signed [31:0] req_end_point = '0;
   logic [31:0] req_sample_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_position;
   logic signed [31:0] rsp_velocity;
   logic signed [31:0] rsp_acceleration;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_move_duration = '0;

   move_request_type  pending_requests[$];
   profile_point_type expected_points[$];
   logic [31:0] duration = cubtr_pkg::DURATION_RESET;
   int   req_idle_pct = 16;
   int   rsp_idle_pct = 64;
   int   mismatches = 0;
   logic req_taken = 1'b0;
   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   cubic_trajectory_point u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_point(req_start_point), .req_end_point(req_end_point),
      .req_sample_time(req_sample_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_position(rsp_position), .rsp_velocity(rsp_velocity),
      .rsp_acceleration(rsp_acceleration), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_move_duration(csr_move_duration)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Adds the signed, floored quotient to base and clips to 32 bits.
   function automatic logic [31:0] floor_clip(longint base, bit neg, wide_type num,
                                              wide_type den, ref bit sat);
      wide_type quo;
      bit       frac;
      longint   val;
      longint   sum;
      quo  = num / den;
      frac = (num % den) != 0;
      if (quo >= (wide_type'(1) << 40)) begin
         val = longint'(1) << 40;
      end else begin
         val = longint'(quo[63:0]) + ((neg && frac) ? 1 : 0);
      end
      sum = neg ? base - val : base + val;
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         sat = 1'b1;
      end
      if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         sat = 1'b1;
      end
      return sum[31:0];
   endfunction

   function automatic profile_point_type cubic_point(move_request_type rq,
                                                     logic [31:0] dur);
      profile_point_type pt;
      longint   s, big_t, tq, dd, k;
      bit       dneg, sat;
      wide_type dm, den, num;
      s     = longint'(rq.start_pt);
      big_t = (dur == 0) ? 1 : longint'({32'd0, dur});
      tq    = longint'({32'd0, rq.when_t});
      dd    = longint'(rq.end_pt) - s;
      dneg  = dd < 0;
      dm    = wide_type'(dneg ? -dd : dd);
      sat   = 1'b0;
      den   = wide_type'(big_t) * wide_type'(big_t) * wide_type'(big_t);

      k   = 3 * big_t - 2 * tq;
      num = dm * wide_type'(tq) * wide_type'(tq) * wide_type'(k < 0 ? -k : k);
      pt.position = floor_clip(s, dneg != (k < 0), num, den, sat);

      k   = big_t - tq;
      num = dm * (wide_type'(6) << 16) * wide_type'(tq) * wide_type'(k < 0 ? -k : k);
      pt.velocity = floor_clip(0, dneg != (k < 0), num, den, sat);

      k   = big_t - 2 * tq;
      num = dm * (wide_type'(6) << 32) * wide_type'(k < 0 ? -k : k);
      pt.acceleration = floor_clip(0, dneg != (k < 0), num, den, sat);

      pt.saturated = sat;
      return pt;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Request driver: a new request goes out only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() > 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_valid       <= 1'b1;
            req_start_point <= pending_requests[0].start_pt;
            req_end_point   <= pending_requests[0].end_pt;
            req_sample_time <= pending_requests[0].when_t;
            void'(pending_requests.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // A long receiver stall, started by the stimulus toggling hold_trigger.
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      move_request_type  rq;
      profile_point_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         rq.start_pt = req_start_point;
         rq.end_pt   = req_end_point;
         rq.when_t   = req_sample_time;
         expected_points.push_back(cubic_point(rq, duration));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = expected_points.pop_front();
            if (rsp_position !== want.position)
               report_mismatch($sformatf("position mismatch: got %h, expected %h",
                                         rsp_position, want.position));
            if (rsp_velocity !== want.velocity)
               report_mismatch($sformatf("velocity mismatch: got %h, expected %h",
                                         rsp_velocity, want.velocity));
            if (rsp_acceleration !== want.acceleration)
               report_mismatch($sformatf("acceleration mismatch: got %h, expected %h",
                                         rsp_acceleration, want.acceleration));
            if (rsp_saturated !== want.saturated)
               report_mismatch($sformatf("saturated mismatch: got %b, expected %b",
                                         rsp_saturated, want.saturated));
         end
      end
   end

   task automatic queue_request(logic [31:0] sp, logic [31:0] ep, logic [31:0] t);
      move_request_type rq;
      rq.start_pt = sp;
      rq.end_pt   = ep;
      rq.when_t   = t;
      pending_requests.push_back(rq);
   endtask

   function automatic logic [31:0] random_point();
      if ($urandom_range(0, 3) == 0)
         return $urandom();
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
   endfunction

   task automatic queue_random(int count);
      logic [31:0] t;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0:       t = $urandom();
            1:       t = duration + $urandom_range(0, 32'h0004_0000);
            default: t = $urandom_range(0, duration);
         endcase
         queue_request(random_point(), random_point(), t);
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_duration(logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_move_duration <= value;
      do @(posedge clock); while (!csr_ready);
      duration = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] durations[6];
      durations = '{32'd65536, 32'd1, 32'hffff_ffff, 32'd196608, 32'd1000, 32'h0000_8000};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edge cases at the one-second reset duration.
      queue_request(32'd0, 32'd65536, 32'd0);
      queue_request(32'd0, 32'd65536, 32'd65536);
      queue_request(32'd0, 32'd65536, 32'd32768);
      queue_request(32'd0, 32'd65536, 32'd131072);
      queue_request(32'd0, 32'd65536, 32'hffff_ffff);
      queue_request(32'h8000_0000, 32'h7fff_ffff, 32'd32768);
      queue_request(32'h7fff_ffff, 32'h8000_0000, 32'd32768);
      queue_request(32'h1234_5678, 32'h1234_5678, 32'd40000);
      queue_request(32'd5, 32'd6, 32'd1);
      queue_request(32'd6, 32'd5, 32'd1);
      queue_request(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      queue_request(32'hffff_ffff, 32'd0, 32'd65535);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            req_idle_pct = 64;
            rsp_idle_pct = 16;
         end else if (ph == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (ph != 0)
            write_duration(durations[ph]);
         if (ph == 1) begin
            queue_request(32'h8000_0000, 32'h7fff_ffff, 32'd0);
            queue_request(32'd0, 32'd1, 32'd1);
            queue_request(32'd0, 32'd1, 32'd2);
         end
         if (ph == 4)
            hold_trigger = ~hold_trigger;
         queue_random(325);
      end
      write_duration(cubtr_pkg::DURATION_RESET);
      queue_random(10);
      wait_drained();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
